// ===== rtl/ole_pkg.sv =====
// Package for the ordered list engine: capacity, operation and status codes,
// transfer payload types and datapath command/status types. No dependencies.
package ole_pkg;
	localparam int Capacity = 16;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);

	localparam logic [3:0] OP_PUSH_BACK = 4'd0;
	localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
	localparam logic [3:0] OP_POP_FRONT = 4'd2;
	localparam logic [3:0] OP_POP_BACK = 4'd3;
	localparam logic [3:0] OP_INSERT = 4'd4;
	localparam logic [3:0] OP_DEL_VALUE = 4'd5;
	localparam logic [3:0] OP_DEL_POS = 4'd6;
	localparam logic [3:0] OP_READ_FWD = 4'd7;
	localparam logic [3:0] OP_READ_REV = 4'd8;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_BADPOS = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	typedef struct packed {
		logic [3:0] kind;
		logic signed [31:0] value;
		logic [7:0] position;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic signed [31:0] data;
		logic [4:0] length;
		logic last;
	} out_item_t;

	// Datapath commands from the controller.
	typedef struct packed {
		logic load;       // capture input item
		logic wr_hold;    // write held value at ptr
		logic wr_rdata;   // write last read data at ptr
		logic ptr_load;   // ptr <= ptr_val
		logic [IdxW:0] ptr_val;
		logic ptr_inc;
		logic ptr_dec;
		logic cnt_inc;
		logic cnt_dec;
	} cmd_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] position;
		logic [CntW-1:0] count;
		logic [IdxW:0] ptr;
		logic match;      // read data equals held value
		logic signed [31:0] rdata;
	} sts_t;
endpackage

// ===== rtl/ole_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ole_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/ole_datapath.sv =====
// Datapath of the ordered list engine: element memory, pointer, fill count,
// held input item. Depends on ole_pkg and ole_ram.
module ole_datapath (
	input logic clk,
	input logic arst_n,
	input ole_pkg::in_item_t in_item,
	input ole_pkg::cmd_t cmd,
	output ole_pkg::sts_t sts
);
	import ole_pkg::*;

	in_item_t item_q;
	logic [CntW-1:0] count_q;
	logic [IdxW:0] ptr_q;
	logic [31:0] rdata;
	logic we;
	logic [31:0] wdata;

	assign we = cmd.wr_hold | cmd.wr_rdata;
	assign wdata = cmd.wr_hold ? item_q.value : rdata;

	ole_ram #(.Width(32), .Depth(Capacity)) u_ram (
		.clk(clk),
		.we(we),
		.waddr(ptr_q[IdxW-1:0]),
		.wdata(wdata),
		.raddr(ptr_q[IdxW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.ptr_load) begin
				ptr_q <= cmd.ptr_val;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	assign sts.kind = item_q.kind;
	assign sts.position = item_q.position;
	assign sts.count = count_q;
	assign sts.ptr = ptr_q;
	assign sts.match = (rdata == item_q.value);
	assign sts.rdata = rdata;
endmodule

// ===== rtl/ole_ctrl.sv =====
// Controller of the ordered list engine: sequences shifts, searches and
// read-outs, and holds the output register. Depends on ole_pkg.
module ole_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	output ole_pkg::out_item_t out_item,
	output ole_pkg::cmd_t cmd,
	input ole_pkg::sts_t sts
);
	import ole_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_OPEN = 3'd2;   // shift up: read ptr-1
	localparam logic [2:0] S_OPEN_W = 3'd3; // read entry ptr, step ptr back up
	localparam logic [2:0] S_CLOSE = 3'd4;  // shift down: read ptr+1
	localparam logic [2:0] S_CLOSE_W = 3'd5;
	localparam logic [2:0] S_SEARCH = 3'd6; // compare read data
	localparam logic [2:0] S_READ = 3'd7;   // emit read-out elements

	logic [2:0] state_q, state_d;
	logic [IdxW:0] target_q, target_d;  // gap index for the shift-up
	logic [IdxW:0] cnt_q, cnt_d;        // results emitted during read-out; shift phase in S_CLOSE_W
	logic rd_pend_q, rd_pend_d;
	logic out_free;
	logic emit;
	out_item_t res;
	logic [IdxW:0] cnt_ext;

	assign cnt_ext = (IdxW + 1)'(sts.count);
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		target_d = target_q;
		cnt_d = cnt_q;
		rd_pend_d = 1'b0;
		cmd = '0;
		emit = 1'b0;
		res = '0;
		res.last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (out_free) begin
					unique case (sts.kind) inside
						OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
							if (sts.count >= CntW'(Capacity)) begin
								emit = 1'b1; res.status = ST_FULL; state_d = S_IDLE;
							end else if (sts.kind == OP_INSERT && sts.count != '0 &&
								{1'b0, sts.position} >= 9'(sts.count)) begin
								emit = 1'b1; res.status = ST_BADPOS; state_d = S_IDLE;
							end else begin
								if (sts.kind == OP_PUSH_BACK || sts.count == '0)
									target_d = cnt_ext;
								else if (sts.kind == OP_PUSH_FRONT)
									target_d = '0;
								else
									target_d = (IdxW + 1)'(sts.position) + 1'b1;
								cmd.ptr_load = 1'b1;
								cmd.ptr_val = cnt_ext;
								state_d = S_OPEN;
							end
						end
						OP_POP_FRONT, OP_POP_BACK, OP_DEL_POS: begin
							if (sts.count == '0) begin
								emit = 1'b1; res.status = ST_EMPTY; state_d = S_IDLE;
							end else if (sts.kind == OP_DEL_POS && (sts.position == '0 ||
								{1'b0, sts.position} > 9'(sts.count))) begin
								emit = 1'b1; res.status = ST_BADPOS; state_d = S_IDLE;
							end else begin
								cmd.ptr_load = 1'b1;
								if (sts.kind == OP_POP_FRONT) cmd.ptr_val = '0;
								else if (sts.kind == OP_POP_BACK) cmd.ptr_val = cnt_ext - 1'b1;
								else cmd.ptr_val = (IdxW + 1)'(sts.position) - 1'b1;
								state_d = S_CLOSE;
							end
						end
						OP_DEL_VALUE: begin
							if (sts.count == '0) begin
								emit = 1'b1; res.status = ST_EMPTY; state_d = S_IDLE;
							end else begin
								cmd.ptr_load = 1'b1;
								cmd.ptr_val = '0;
								rd_pend_d = 1'b1;
								state_d = S_SEARCH;
							end
						end
						OP_READ_FWD, OP_READ_REV: begin
							if (sts.count == '0) begin
								emit = 1'b1; res.status = ST_EMPTY; state_d = S_IDLE;
							end else begin
								cmd.ptr_load = 1'b1;
								cmd.ptr_val = (sts.kind == OP_READ_FWD) ? '0 : cnt_ext - 1'b1;
								cnt_d = '0;
								rd_pend_d = 1'b1;
								state_d = S_READ;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_OPEN: begin
				// ptr is the free slot; move entry ptr-1 up until ptr hits target.
				if (sts.ptr == target_q) begin
					cmd.wr_hold = 1'b1;
					cmd.cnt_inc = 1'b1;
					emit = 1'b1;
					res.length = 5'(sts.count + 1'b1);
					state_d = S_IDLE;
				end else begin
					cmd.ptr_dec = 1'b1;
					state_d = S_OPEN_W;
				end
			end
			S_OPEN_W: begin
				// Entry ptr is being read; S_CLOSE_W stores it one slot up.
				cmd.ptr_inc = 1'b1;
				target_d = target_q;
				state_d = S_CLOSE_W;
				cnt_d = (IdxW + 1)'(1);
			end
			S_CLOSE: begin
				// ptr is the slot to fill from ptr+1.
				if (sts.ptr + 1'b1 >= cnt_ext) begin
					cmd.cnt_dec = 1'b1;
					emit = 1'b1;
					res.length = 5'(sts.count - 1'b1);
					state_d = S_IDLE;
				end else begin
					cmd.ptr_inc = 1'b1;
					cnt_d = '0;
					state_d = S_CLOSE_W;
				end
			end
			S_CLOSE_W: begin
				// Write the registered read data once it holds the source entry.
				if (cnt_q[0]) begin
					// Shift up: write at ptr, then step back down.
					cmd.wr_rdata = 1'b1;
					cmd.ptr_dec = 1'b1;
					state_d = S_OPEN;
				end else begin
					cmd.ptr_dec = 1'b1;
					rd_pend_d = 1'b1;
					state_d = S_CLOSE_W;
					cnt_d = (IdxW + 1)'(2);
					if (cnt_q[1]) begin
						cmd.ptr_dec = 1'b0;
						cmd.wr_rdata = 1'b1;
						cmd.ptr_inc = 1'b1;
						rd_pend_d = 1'b0;
						state_d = S_CLOSE;
					end
				end
			end
			S_SEARCH: begin
				if (!rd_pend_q) begin
					if (sts.match) begin
						state_d = S_CLOSE;
					end else if (sts.ptr + 1'b1 >= cnt_ext) begin
						emit = 1'b1;
						res.status = ST_NOTFOUND;
						state_d = S_IDLE;
					end else begin
						cmd.ptr_inc = 1'b1;
						rd_pend_d = 1'b1;
					end
				end
			end
			S_READ: begin
				if (!rd_pend_q && out_free) begin
					emit = 1'b1;
					res.data = sts.rdata;
					res.last = (cnt_q + 1'b1 == cnt_ext);
					cnt_d = cnt_q + 1'b1;
					if (res.last) begin
						state_d = S_IDLE;
					end else begin
						rd_pend_d = 1'b1;
						if (sts.kind == OP_READ_FWD) cmd.ptr_inc = 1'b1;
						else cmd.ptr_dec = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (!(state_q == S_OPEN && sts.ptr == target_q) &&
			!(state_q == S_CLOSE && sts.ptr + 1'b1 >= cnt_ext))
			res.length = 5'(sts.count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			target_q <= '0;
			cnt_q <= '0;
			rd_pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			target_q <= target_d;
			cnt_q <= cnt_d;
			rd_pend_q <= rd_pend_d;
			if (emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_item <= res;
	end
endmodule

// ===== rtl/ordered_list_engine_core.sv =====
// Ordered list engine: a deque of up to Capacity signed 32-bit words kept
// packed in one memory. Each operation is accepted in the idle state and
// then decoded; shifting inserts and deletes then move one element at a
// time, each move reading an entry through the registered read port and
// writing it back through the same pointer, a value search compares one
// element at a time, and a read-out delivers its transfers one after
// another. Refused operations finish in the decode state. The decode state
// waits while an earlier result is still stalled in the output register,
// and each read-out transfer waits for that register as well. Operation
// codes 9 to 15 are dropped with no transfer. Results wait in an output
// register; the input side stalls while an operation is in progress.
module ordered_list_engine_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ole_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output ole_pkg::out_item_t out_item
);
	import ole_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ole_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cmd(cmd), .sts(sts)
	);

	ole_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .sts(sts)
	);
endmodule

// ===== rtl/ole_checker.sv =====
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on ole_pkg.
module ole_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input ole_pkg::out_item_t out_item
);
	import ole_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.length <= 5'(Capacity))
		else $error("length beyond capacity");
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |-> out_item.data == '0 && out_item.last)
		else $error("error result malformed");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted while busy");
endmodule

bind ordered_list_engine_core ole_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

// ===== dv/ordered_list_engine_core_test.sv =====
// Self-checking testbench for ordered_list_engine_core: random and directed
// list operations, predicted by a behavioral deque model and checked per transfer.
// Depends on ole_pkg and the core RTL.
`timescale 1ns / 100ps

module ordered_list_engine_core_test;
	import ole_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	ordered_list_engine_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// Free-running clock with a 2 ns period.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Items waiting to be offered, and results the list model says must come back.
	in_item_t pending_ops[$];
	out_item_t expected_results[$];
	int error_count = 0;

	// Idling knobs, in percent, changed by the stimulus process between phases.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	// While set, the receiver stalls without a break.
	logic hold_off = 1'b0;

	// Behavioral copy of the list contents, kept in list order from index 0.
	logic signed [31:0] list_words[Capacity];
	int list_len = 0;

	function automatic void add_op(in_item_t op);
		pending_ops.insert(pending_ops.size(), op);
	endfunction

	function automatic void add_expect(out_item_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic out_item_t make_result(logic [2:0] st, logic signed [31:0] d,
			logic fin);
		out_item_t r;
		r.status = st;
		r.data = d;
		r.length = list_len[4:0];
		r.last = fin;
		return r;
	endfunction

	// Opens a gap at index at and stores the word there.
	function automatic void list_put(int at, logic signed [31:0] w);
		for (int i = list_len; i > at; i--)
			list_words[i] = list_words[i - 1];
		list_words[at] = w;
		list_len++;
	endfunction

	function automatic void list_take(int at);
		for (int i = at; i + 1 < list_len; i++)
			list_words[i] = list_words[i + 1];
		list_len--;
	endfunction

	// Applies one accepted operation to the model and queues its results.
	function automatic void predict_list_op(in_item_t op);
		logic [2:0] st;
		int hit;
		st = ST_OK;
		hit = -1;
		case (op.kind) inside
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (list_len >= Capacity)
					st = ST_FULL;
				else
					list_put(op.kind == OP_PUSH_BACK ? list_len : 0, op.value);
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else
					list_take(op.kind == OP_POP_FRONT ? 0 : list_len - 1);
			end
			OP_INSERT: begin
				if (list_len >= Capacity)
					st = ST_FULL;
				else if (list_len == 0)
					list_put(0, op.value);
				else if (op.position >= list_len)
					st = ST_BADPOS;
				else
					list_put(op.position + 1, op.value);
			end
			OP_DEL_VALUE: begin
				if (list_len == 0) begin
					st = ST_EMPTY;
				end else begin
					for (int i = 0; i < list_len; i++)
						if (hit < 0 && list_words[i] == op.value)
							hit = i;
					if (hit < 0)
						st = ST_NOTFOUND;
					else
						list_take(hit);
				end
			end
			OP_DEL_POS: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else if (op.position == 0 || op.position > list_len)
					st = ST_BADPOS;
				else
					list_take(op.position - 1);
			end
			OP_READ_FWD, OP_READ_REV: begin
				if (list_len == 0) begin
					add_expect(make_result(ST_EMPTY, 0, 1'b1));
				end else begin
					for (int i = 0; i < list_len; i++)
						add_expect(make_result(ST_OK,
							list_words[op.kind == OP_READ_FWD ? i : list_len - 1 - i],
							i + 1 == list_len));
				end
				return;
			end
			default: return;
		endcase
		add_expect(make_result(st, 0, 1'b1));
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// Driver: offers the head of the pending queue; holds it steady while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_list_op(in_item);
			end
			if (!in_valid || !in_stall) begin
				// The previous transfer, if any, has been taken; pick the next item.
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_ops[0];
					pending_ops.delete(0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares every accepted result with the oldest expectation,
	// and drives the receiver's stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %p", out_item));
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (out_item.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							out_item.status, want.status));
					if (out_item.data !== want.data)
						report_mismatch($sformatf("data %0d, want %0d",
							out_item.data, want.data));
					if (out_item.length !== want.length)
						report_mismatch($sformatf("length %0d, want %0d",
							out_item.length, want.length));
					if (out_item.last !== want.last)
						report_mismatch($sformatf("last %0b, want %0b",
							out_item.last, want.last));
				end
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Random value that favors the extremes and a small pool, so that
	// value deletes find matches often.
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t make_op(logic [3:0] k, logic signed [31:0] v,
			logic [7:0] p);
		in_item_t op;
		op.kind = k;
		op.value = v;
		op.position = p;
		return op;
	endfunction

	// Random operation: mostly legal kinds, positions mostly from 0 to Capacity+1.
	function automatic in_item_t random_op(int grow_bias);
		logic [3:0] k;
		logic [7:0] p;
		int r;
		r = $urandom_range(99);
		if (r < 3)
			k = 4'($urandom_range(15, 9));
		else if (r < 3 + grow_bias)
			k = ($urandom_range(2) == 0) ? OP_INSERT : 4'($urandom_range(1));
		else
			k = 4'($urandom_range(8));
		p = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(Capacity + 1));
		return make_op(k, pick_word(), p);
	endfunction

	task automatic wait_drained();
		while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		// An ignored kind gives no result; let the block settle after it.
		repeat (40) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-list cases, extremes, fill to capacity, refusals.
		add_op(make_op(OP_READ_FWD, 0, 0));
		add_op(make_op(OP_POP_FRONT, 0, 0));
		add_op(make_op(OP_POP_BACK, 0, 0));
		add_op(make_op(OP_DEL_VALUE, 5, 0));
		add_op(make_op(OP_DEL_POS, 0, 1));
		add_op(make_op(OP_INSERT, 32'sh80000000, 8'hff));
		add_op(make_op(OP_PUSH_BACK, 32'sh7fffffff, 0));
		add_op(make_op(OP_PUSH_FRONT, -1, 0));
		add_op(make_op(OP_INSERT, 9, 3));
		add_op(make_op(OP_INSERT, 10, 0));
		add_op(make_op(OP_DEL_POS, 0, 0));
		add_op(make_op(OP_DEL_POS, 0, 9));
		add_op(make_op(OP_DEL_VALUE, 12345, 0));
		add_op(make_op(4'd15, 0, 0));
		add_op(make_op(4'd9, 0, 0));
		for (int i = 0; i < Capacity; i++)
			add_op(make_op(OP_PUSH_BACK, i * 3 - 20, 0));
		add_op(make_op(OP_READ_REV, 0, 0));
		add_op(make_op(OP_INSERT, 1, 0));
		add_op(make_op(OP_PUSH_FRONT, 1, 0));
		add_op(make_op(OP_DEL_VALUE, -20, 0));
		add_op(make_op(OP_DEL_POS, 0, 8'd255));
		add_op(make_op(OP_READ_FWD, 0, 0));
		wait_drained();

		// Random phases with different idling on each side.
		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 56 : 26) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 56 : 26) : 0;
			for (int n = 0; n < 80; n++)
				add_op(random_op((n / 20) % 2 == 0 ? 50 : 5));
			if (ph == 0) begin
				// Long receiver hold-off while the sender keeps offering.
				@(posedge clk);
				fork
					begin
						hold_off <= 1'b1;
						repeat (300) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			wait_drained();
		end

		// Short burst with no idling after the sender paused for the drain above.
		send_gap_pct = 0;
		recv_stall_pct = 0;
		for (int n = 0; n < 30; n++)
			add_op(random_op(20));
		wait_drained();

		if (error_count == 0)
			$display("PASS ordered_list_engine_core");
		else
			$display("FAIL ordered_list_engine_core");
		$finish;
	end

	// Run-time limit, far above the slowest legal run.
	initial begin
		#2000000;
		$display("FAIL ordered_list_engine_core");
		$finish;
	end
endmodule
